// ===== design/atp_pkg.sv =====
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and constants for the fixed point atan2 (turns) pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package atp_pkg;

  // Field widths
  localparam int unsigned COMP_W  = 32;  // vector component width
  localparam int unsigned QUO_W   = 17;  // ratio width, range [0, 0x10000] for a nonzero vector
  localparam int unsigned INNER_W = 12;  // inner polynomial term, max 0x0B20
  localparam int unsigned OCT_W   = 15;  // octant angle, max 0x2000
  localparam int unsigned ANG_W   = 16;  // output angle width

  // One quotient bit is resolved per divider stage
  localparam int unsigned DIV_STEPS = QUO_W;

  // Constants of the approximation and the fold
  localparam logic [ANG_W-1:0]   ZERO_ANGLE   = 16'hC000;
  localparam logic [13:0]        POLY_BASE    = 14'h2000;
  localparam logic [INNER_W-1:0] POLY_SLOPE   = 12'hB20;
  localparam logic [QUO_W-1:0]   FIX_ONE      = 17'h10000;
  localparam logic [ANG_W-1:0]   QUARTER_TURN = 16'h4000;
  localparam logic [ANG_W-1:0]   HALF_TURN    = 16'h8000;

  // Octant and special-case flags that ride along with each vector
  typedef struct packed {
    logic zero;      // both components zero
    logic swapped;   // |y| > |x|, octant swapped
    logic mirrored;  // x negative
    logic negated;   // math-space y negative (screen y strictly positive)
  } atp_flags_t;

  // Divider working word
  typedef struct packed {
    atp_flags_t        flags;
    logic [COMP_W-1:0] rem;   // partial remainder, below den after each step
    logic [COMP_W-1:0] den;   // larger magnitude
    logic [QUO_W-1:0]  quo;   // quotient bits so far
  } atp_div_t;

  // Ratio handed to the polynomial section
  typedef struct packed {
    atp_flags_t       flags;
    logic [QUO_W-1:0] ratio;
  } atp_ratio_t;

endpackage

`default_nettype wire

// ===== design/atp_prep.sv =====
// ----------------------------------------------------------------------------
// atp_prep
// Front stage: magnitudes, octant flags and divider operand selection.
// ----------------------------------------------------------------------------
`default_nettype none

module atp_prep (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  wire  [atp_pkg::COMP_W-1:0]       delta_x,
  input  wire  [atp_pkg::COMP_W-1:0]       delta_y,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output atp_pkg::atp_div_t                dn_data
);

  logic                        vld_r;
  atp_pkg::atp_div_t           data_r;
  atp_pkg::atp_div_t           data_nxt;
  logic [atp_pkg::COMP_W-1:0]  mag_x;
  logic [atp_pkg::COMP_W-1:0]  mag_y;
  logic                        swap;

  // Unsigned magnitudes; the most negative value maps to 2^31 exactly
  assign mag_x = delta_x[atp_pkg::COMP_W-1] ? (atp_pkg::COMP_W'(0) - delta_x) : delta_x;
  assign mag_y = delta_y[atp_pkg::COMP_W-1] ? (atp_pkg::COMP_W'(0) - delta_y) : delta_y;
  assign swap  = mag_y > mag_x;

  // Smaller magnitude seeds the remainder, larger one is the divisor
  always_comb begin
    data_nxt                = '0;
    data_nxt.flags.zero     = (delta_x == '0) && (delta_y == '0);
    data_nxt.flags.swapped  = swap;
    data_nxt.flags.mirrored = delta_x[atp_pkg::COMP_W-1];
    data_nxt.flags.negated  = (delta_y != '0) && !delta_y[atp_pkg::COMP_W-1];
    data_nxt.rem            = swap ? mag_x : mag_y;
    data_nxt.den            = swap ? mag_y : mag_x;
    data_nxt.quo            = '0;
  end

  // Stage loads when empty or when the next stage takes its request
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== design/atp_div.sv =====
// ----------------------------------------------------------------------------
// atp_div
// Pipelined restoring divider, one quotient bit per stage, computing
// floor((num << 16) / den) for num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module atp_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   up_valid,
  output logic                  up_ready,
  input  atp_pkg::atp_div_t     up_data,
  output logic                  dn_valid,
  input  wire                   dn_ready,
  output atp_pkg::atp_ratio_t   dn_data
);

  localparam int unsigned N = atp_pkg::DIV_STEPS;
  localparam int unsigned W = atp_pkg::COMP_W;

  logic              vld_r [N];
  atp_pkg::atp_div_t stg_r [N];
  logic              rdy   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic              src_vld;
    atp_pkg::atp_div_t src;
    atp_pkg::atp_div_t stg_nxt;
    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              take;

    // Source of this stage
    if (k == 0) begin : g_first
      assign src_vld = up_valid;
      assign src     = up_data;
      // Top quotient bit: remainder is the smaller magnitude itself
      assign trial   = {1'b0, src.rem};
    end else begin : g_next
      assign src_vld = vld_r[k-1];
      assign src     = stg_r[k-1];
      assign trial   = {src.rem, 1'b0};
    end

    // Downstream ready for this stage
    if (k == N-1) begin : g_last
      assign rdy[k] = !vld_r[k] || dn_ready;
    end else begin : g_mid
      assign rdy[k] = !vld_r[k] || rdy[k+1];
    end

    // Compare and subtract
    assign diff = trial - {1'b0, src.den};
    assign take = !diff[W];

    always_comb begin
      stg_nxt       = src;
      stg_nxt.rem   = take ? diff[W-1:0] : trial[W-1:0];
      stg_nxt.quo   = {src.quo[atp_pkg::QUO_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign up_ready      = rdy[0];
  assign dn_valid      = vld_r[N-1];
  assign dn_data.flags = stg_r[N-1].flags;
  assign dn_data.ratio = stg_r[N-1].quo;

endmodule

`default_nettype wire

// ===== design/atp_poly.sv =====
// ----------------------------------------------------------------------------
// atp_poly
// Octant polynomial r*(0x2000 + 0x0B20*(1-r)) in two multiply stages,
// then the fold into a full turn in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atp_poly (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          up_valid,
  output logic                         up_ready,
  input  atp_pkg::atp_ratio_t          up_data,
  output logic                         dn_valid,
  input  wire                          dn_ready,
  output logic [atp_pkg::ANG_W-1:0]    dn_angle
);

  localparam int unsigned QW = atp_pkg::QUO_W;
  localparam int unsigned IW = atp_pkg::INNER_W;
  localparam int unsigned OW = atp_pkg::OCT_W;
  localparam int unsigned AW = atp_pkg::ANG_W;
  localparam int unsigned PA_W = IW + QW;    // slope times (1 - r)
  localparam int unsigned PB_W = QW + 14;    // r times (base + inner)

  // Stage A: inner term
  logic                   a_vld_r;
  logic                   a_rdy;
  atp_pkg::atp_flags_t    a_flags_r;
  logic [QW-1:0]          a_ratio_r;
  logic [IW-1:0]          a_inner_r;
  logic [IW-1:0]          a_inner_nxt;
  logic [QW-1:0]          one_minus_r;
  logic [PA_W-1:0]        prod_a;

  // Stage B: octant angle
  logic                   b_vld_r;
  logic                   b_rdy;
  atp_pkg::atp_flags_t    b_flags_r;
  logic [OW-1:0]          b_oct_r;
  logic [OW-1:0]          b_oct_nxt;
  logic [13:0]            coef;
  logic [PB_W-1:0]        prod_b;

  // Stage C: fold, output register
  logic                   c_vld_r;
  logic                   c_rdy;
  logic [AW-1:0]          c_angle_r;
  logic [AW-1:0]          c_angle_nxt;
  logic [AW-1:0]          fold_s;
  logic [AW-1:0]          fold_m;
  logic [AW-1:0]          fold_n;

  // Ready chain, output register last
  assign c_rdy    = !c_vld_r || dn_ready;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  // Inner term: (0x0B20 * (0x10000 - r)) >> 16
  assign one_minus_r = atp_pkg::FIX_ONE - up_data.ratio;
  assign prod_a      = PA_W'(atp_pkg::POLY_SLOPE) * PA_W'(one_minus_r);
  assign a_inner_nxt = prod_a[IW+15:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      a_flags_r <= up_data.flags;
      a_ratio_r <= up_data.ratio;
      a_inner_r <= a_inner_nxt;
    end
  end

  // Octant angle: (r * (0x2000 + inner)) >> 16
  assign coef      = atp_pkg::POLY_BASE + 14'(a_inner_r);
  assign prod_b    = PB_W'(a_ratio_r) * PB_W'(coef);
  assign b_oct_nxt = prod_b[OW+15:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_vld_r) begin
      b_flags_r <= a_flags_r;
      b_oct_r   <= b_oct_nxt;
    end
  end

  // Fold by swap, mirror and negate, modulo one turn
  assign fold_s = b_flags_r.swapped  ? (atp_pkg::QUARTER_TURN - AW'(b_oct_r)) : AW'(b_oct_r);
  assign fold_m = b_flags_r.mirrored ? (atp_pkg::HALF_TURN - fold_s) : fold_s;
  assign fold_n = b_flags_r.negated  ? (AW'(0) - fold_m) : fold_m;
  assign c_angle_nxt = b_flags_r.zero ? atp_pkg::ZERO_ANGLE : fold_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_rdy) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_vld_r) begin
      c_angle_r <= c_angle_nxt;
    end
  end

  assign dn_valid = c_vld_r;
  assign dn_angle = c_angle_r;

endmodule

`default_nettype wire

// ===== design/fixed_point_atan2_turns.sv =====
// ----------------------------------------------------------------------------
// fixed_point_atan2_turns
// Angle of a screen-space 16.16 vector as a 16-bit fraction of a turn.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one vector per request: delta_x and delta_y, signed
//   16.16, screen space with y down. Output stream carries one angle per
//   request, 65536 units per turn, math space with y up. A zero vector
//   gives 0xC000.
//   From input accept to output valid a vector passes one stage for
//   magnitudes and octant select, 17 divider stages (one quotient bit per
//   stage of the ratio smaller/larger), two multiply stages for the octant
//   polynomial and the fold in the output register.
//   Throughput is one vector per cycle while out_tready stays high; every
//   stage holds one request and the divider's 17 stages are most of the depth.
//   Reset (rst_n low at a clock edge) empties the pipeline; in_tready is
//   high once reset is released.
//   When the receiver stalls, the output request holds and earlier stages
//   keep filling empty slots; in_tready falls only when every stage is full.
//   Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_atan2_turns (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [31:0] delta_x, [63:32] delta_y
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [15:0] angle_turns
);

  logic                 prep_vld;
  logic                 div_rdy;
  atp_pkg::atp_div_t    prep_data;
  logic                 div_vld;
  logic                 poly_rdy;
  atp_pkg::atp_ratio_t  div_data;

  atp_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .delta_x  (in_tdata[31:0]),
    .delta_y  (in_tdata[63:32]),
    .dn_valid (prep_vld),
    .dn_ready (div_rdy),
    .dn_data  (prep_data)
  );

  atp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_vld),
    .up_ready (div_rdy),
    .up_data  (prep_data),
    .dn_valid (div_vld),
    .dn_ready (poly_rdy),
    .dn_data  (div_data)
  );

  atp_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_vld),
    .up_ready (poly_rdy),
    .up_data  (div_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_angle (out_tdata)
  );

`ifndef ASSERT_OFF
  // Ratio never exceeds one for a nonzero vector
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld && !div_data.flags.zero |-> div_data.ratio <= atp_pkg::FIX_ONE)
    else $error("divider ratio above one");

  // Front stage empty means the input side can take a request
  a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !prep_vld |-> in_tready)
    else $error("input stalled with empty front stage");

  // A stalled front-stage request stays in place with its operands
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    prep_vld && !div_rdy |=> prep_vld && $stable(prep_data))
    else $error("front stage request lost under stall");
`endif

endmodule

`default_nettype wire
